@@ rtl/sdbm_pkg.sv @@
package sdbm_pkg;

	// fixed field and word widths
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;
	localparam int MOD_W     = 9;
	localparam int OFF_W     = 8;
	localparam int POS_W     = 10;
	localparam int WNUM_W    = POS_W - BIT_W;
	localparam int HASH_W    = 31;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 9;
	localparam int DIV_CNT_W = 5;

	// hash multiplier and saturation limit
	localparam logic [31:0]      HASH_MUL  = 32'd4999;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hffff;

	// register map bases
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_BASE = 3'd4;

	// request action codes
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_MATCH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// input request payload
	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  key_index;
		logic        key_bound;
		logic [31:0] key_value;
		logic        fact_end;
		logic [2:0]  word_index;
		logic [31:0] other_word;
		logic        last_word;
	} item_t;

	// result payload
	typedef struct packed {
		logic             is_subset;
		logic [CNT_W-1:0] records_added;
	} result_t;

	// modulo unit command and status
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] dividend;
		logic [MOD_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ rtl/superimposed_descriptor_build_match_core.sv @@
// Superimposed-coding signature builder and subset matcher.
// Requests arrive on item_valid / item_stall / item and are taken at an edge
// with item_valid high and item_stall low. A clear request empties the
// descriptor and the record count. An add request hashes one key and sets
// one descriptor bit through the hash multiply, the 31-step radix-2 modulo
// unit and a read-modify-write of the word memory (no write is done when the
// position falls past the store).
// An add whose key is unbound or disabled leaves the block idle. A match
// request compares one stored word with the offered word; the request with
// last_word set then waits in S_EMIT to load one result onto result_valid /
// result_stall / result, holding the subset flag and the current record count.
// item_stall stays high while a request is in progress; one request is
// worked at a time. Results sit in an output register: a stalled result holds
// its value, and the block keeps taking requests until a further result finds
// the register still occupied, where it waits.
// Key moduli and offsets are written on cfg_valid / cfg_ready while idle.
// Reset clears the descriptor (per-word valid bits), the count, the
// configuration and the output valid flag; no clearing pass is needed.
module superimposed_descriptor_build_match_core #(
	parameter int DESC_WORDS = 8,
	parameter int NUM_KEYS   = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  sdbm_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output sdbm_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sdbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sdbm_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int AW = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_HASH  = 9'b000000010,
		S_DIVGO = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_READ  = 9'b000010000,
		S_WRITE = 9'b000100000,
		S_MREAD = 9'b001000000,
		S_MCMP  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [sdbm_pkg::MOD_W-1:0]  mod_cfg_q [NUM_KEYS];
	logic [sdbm_pkg::OFF_W-1:0]  off_cfg_q [NUM_KEYS];

	logic [DESC_WORDS-1:0]        wvalid_q;
	logic [sdbm_pkg::CNT_W-1:0]   count_q;
	logic                         run_q;

	logic [31:0]                  value_q;
	logic [sdbm_pkg::MOD_W-1:0]   mod_q;
	logic [sdbm_pkg::OFF_W-1:0]   off_q;
	logic [sdbm_pkg::HASH_W-1:0]  hash_q;
	logic [sdbm_pkg::WNUM_W-1:0]  wnum_q;
	logic [sdbm_pkg::BIT_W-1:0]   bit_q;
	logic [31:0]                  other_q;
	logic                         last_q;

	logic                         res_valid_q;
	sdbm_pkg::result_t            res_q;

	logic                         item_fire;
	logic                         cfg_fire;
	logic [sdbm_pkg::MOD_W-1:0]   sel_mod;
	logic [sdbm_pkg::OFF_W-1:0]   sel_off;
	logic                         key_ok;
	logic [31:0]                  product;
	logic [sdbm_pkg::POS_W-1:0]   pos;
	logic                         in_range;
	logic [AW-1:0]                addr;
	logic [31:0]                  mine;
	logic                         can_load;

	sdbm_pkg::div_req_t           div_req;
	sdbm_pkg::div_rsp_t           div_rsp;

	logic                         ram_we;
	logic                         ram_re;
	logic [31:0]                  ram_wdata;
	logic [31:0]                  ram_rdata;

	assign item_fire  = item_valid && !item_stall;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready  = (state_q == S_IDLE);

	// key register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				mod_cfg_q[k] <= '0;
				off_cfg_q[k] <= '0;
			end
		end else if (cfg_fire) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (cfg_index == sdbm_pkg::CFG_MOD_BASE + sdbm_pkg::CFG_IDX_W'(k)) begin
					mod_cfg_q[k] <= cfg_data;
				end
				if (cfg_index == sdbm_pkg::CFG_OFF_BASE + sdbm_pkg::CFG_IDX_W'(k)) begin
					off_cfg_q[k] <= cfg_data[sdbm_pkg::OFF_W-1:0];
				end
			end
		end
	end

	// key select for the incoming request
	always_comb begin
		sel_mod = '0;
		sel_off = '0;
		key_ok  = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (item.key_index == 2'(k)) begin
				sel_mod = mod_cfg_q[k];
				sel_off = off_cfg_q[k];
				key_ok  = 1'b1;
			end
		end
	end

	// hash multiply, low 31 bits kept
	assign product = value_q * sdbm_pkg::HASH_MUL;

	// bit position from remainder plus offset
	assign pos = {1'b0, div_rsp.rem} + {2'b00, off_q};

	// word range check and memory address
	assign in_range = (32'(wnum_q) < 32'(DESC_WORDS));
	assign addr     = AW'(wnum_q);
	assign mine     = (in_range && wvalid_q[addr]) ? ram_rdata : '0;
	assign can_load = !res_valid_q || !result_stall;

	// modulo unit hookup
	assign div_req.start    = (state_q == S_DIVGO);
	assign div_req.dividend = hash_q;
	assign div_req.divisor  = mod_q;

	sdbm_moddiv u_moddiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// descriptor word memory
	assign ram_re    = ((state_q == S_READ) || (state_q == S_MREAD)) && in_range;
	assign ram_we    = (state_q == S_WRITE);
	assign ram_wdata = mine | (32'd1 << bit_q);

	sdbm_ram #(
		.WIDTH (sdbm_pkg::WORD_BITS),
		.DEPTH (DESC_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wvalid_q <= '0;
			count_q  <= '0;
			run_q    <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						unique case (item.action)
							sdbm_pkg::ACT_CLEAR: begin
								wvalid_q <= '0;
								count_q  <= '0;
								run_q    <= 1'b1;
							end
							sdbm_pkg::ACT_ADD: begin
								if (item.fact_end && count_q != sdbm_pkg::COUNT_MAX) begin
									count_q <= count_q + 1'b1;
								end
								if (item.key_bound && key_ok && sel_mod != '0) begin
									state_q <= S_HASH;
								end
							end
							sdbm_pkg::ACT_MATCH: begin
								state_q <= S_MREAD;
							end
							default: begin
							end
						endcase
					end
				end
				S_HASH: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= in_range ? S_WRITE : S_IDLE;
				end
				S_WRITE: begin
					wvalid_q[addr] <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_MREAD: begin
					state_q <= S_MCMP;
				end
				S_MCMP: begin
					run_q   <= run_q && ((mine & other_q) == mine);
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (can_load) begin
						run_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and working registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			value_q <= item.key_value;
			mod_q   <= sel_mod;
			off_q   <= sel_off;
			other_q <= item.other_word;
			last_q  <= item.last_word;
			wnum_q  <= {2'b00, item.word_index};
		end
		if (state_q == S_HASH) begin
			hash_q <= product[sdbm_pkg::HASH_W-1:0];
		end
		if (state_q == S_DIV && div_rsp.done) begin
			wnum_q <= pos[sdbm_pkg::POS_W-1:sdbm_pkg::BIT_W];
			bit_q  <= pos[sdbm_pkg::BIT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && can_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && can_load) begin
			res_q.is_subset     <= run_q;
			res_q.records_added <= count_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// checks
	a_we_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> in_range)
		else $error("descriptor write outside the store");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("modulo unit finished outside its wait state");

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (div_rsp.rem < mod_q))
		else $error("remainder not below modulus");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !res_valid_q) |=> (res_valid_q && state_q == S_IDLE))
		else $error("result not loaded into an empty output register");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && item.action == sdbm_pkg::ACT_CLEAR) |=>
			(count_q == '0 && run_q && wvalid_q == '0))
		else $error("clear request left state behind");

endmodule

@@ rtl/sdbm_ram.sv @@
module sdbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sdbm_moddiv.sv @@
module sdbm_moddiv (
	input  logic              clk,
	input  logic              arst_n,
	input  sdbm_pkg::div_req_t req,
	output sdbm_pkg::div_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [sdbm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [sdbm_pkg::HASH_W-1:0]     dvd_q;
	logic [sdbm_pkg::MOD_W-1:0]      dsr_q;
	logic [sdbm_pkg::MOD_W-1:0]      rem_q;
	logic [sdbm_pkg::MOD_W:0]        trial;
	logic [sdbm_pkg::MOD_W:0]        diff;

	// one restoring step: shift in next dividend bit, subtract if it fits
	assign trial = {rem_q, dvd_q[sdbm_pkg::HASH_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sdbm_pkg::DIV_CNT_W'(sdbm_pkg::HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[sdbm_pkg::HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[sdbm_pkg::MOD_W-1:0];
			end else begin
				rem_q <= trial[sdbm_pkg::MOD_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ test/superimposed_descriptor_build_match_core_tb.sv @@
`timescale 1ns / 1ps

module superimposed_descriptor_build_match_core_tb;

	localparam int          DESC_WORDS  = 8;
	localparam int          NUM_KEYS    = 4;
	localparam logic [31:0] HASH_FACTOR = 32'd4999;
	localparam logic [15:0] FACT_CEIL   = 16'hffff;
	// an add request can keep the block busy this long after its last report
	localparam int          BUSY_CYCLES = 48;
	localparam int          IDLE_LIMIT  = 4000;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	sdbm_pkg::item_t                item;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	sdbm_pkg::result_t              result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [sdbm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sdbm_pkg::CFG_DAT_W-1:0] cfg_data;

	// shadow of the block: descriptor, fact count, running match flag, key setup
	logic [31:0]       desc_words [DESC_WORDS];
	logic [15:0]       fact_count;
	logic              subset_so_far;
	logic [8:0]        key_mod [NUM_KEYS];
	logic [7:0]        key_off [NUM_KEYS];
	sdbm_pkg::result_t reports_due [$];

	int error_count;
	int requests_sent;
	int reports_seen;
	int reg_writes;
	int idle_cycles = 0;
	int hold_left = 0;
	bit steady;

	superimposed_descriptor_build_match_core #(
		.DESC_WORDS(DESC_WORDS),
		.NUM_KEYS(NUM_KEYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short pauses, now and then a long one, none in steady stretches
	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic sdbm_pkg::item_t random_item();
		sdbm_pkg::item_t r;
		r.action     = 2'($urandom_range(0, 3));
		r.key_index  = 2'($urandom_range(0, 3));
		r.key_bound  = 1'($urandom_range(0, 1));
		r.key_value  = $urandom();
		r.fact_end   = 1'($urandom_range(0, 1));
		r.word_index = 3'($urandom_range(0, 7));
		r.other_word = $urandom();
		r.last_word  = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic sdbm_pkg::item_t add_item(logic [1:0] idx, logic bound,
			logic [31:0] value, logic fend);
		sdbm_pkg::item_t r;
		r           = random_item();
		r.action    = sdbm_pkg::ACT_ADD;
		r.key_index = idx;
		r.key_bound = bound;
		r.key_value = value;
		r.fact_end  = fend;
		return r;
	endfunction

	function automatic sdbm_pkg::item_t match_item(logic [2:0] w, logic [31:0] other,
			logic last);
		sdbm_pkg::item_t r;
		r            = random_item();
		r.action     = sdbm_pkg::ACT_MATCH;
		r.word_index = w;
		r.other_word = other;
		r.last_word  = last;
		return r;
	endfunction

	// apply one accepted request to the shadow and queue any subset report
	task automatic fold_request(input sdbm_pkg::item_t r);
		logic [31:0]       prod;
		logic [31:0]       pos;
		logic [31:0]       mine;
		sdbm_pkg::result_t due;
		case (r.action)
			sdbm_pkg::ACT_CLEAR: begin
				foreach (desc_words[i])
					desc_words[i] = '0;
				fact_count    = '0;
				subset_so_far = 1'b1;
			end
			sdbm_pkg::ACT_ADD: begin
				if (r.key_bound && key_mod[r.key_index] != '0) begin
					prod = r.key_value * HASH_FACTOR;
					pos  = ({1'b0, prod[30:0]} % {23'd0, key_mod[r.key_index]})
						+ {24'd0, key_off[r.key_index]};
					// positions past the store are dropped
					if (pos / 32 < DESC_WORDS)
						desc_words[pos / 32][pos % 32] = 1'b1;
				end
				if (r.fact_end && fact_count != FACT_CEIL)
					fact_count = fact_count + 16'd1;
			end
			sdbm_pkg::ACT_MATCH: begin
				mine = desc_words[r.word_index];
				if ((mine & r.other_word) != mine)
					subset_so_far = 1'b0;
				if (r.last_word) begin
					due.is_subset     = subset_so_far;
					due.records_added = fact_count;
					reports_due.push_back(due);
					subset_so_far = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// offer one request; valid stays up so back-to-back requests need no toggle
	task automatic send_request(input sdbm_pkg::item_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= r;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		fold_request(r);
		requests_sent++;
	endtask

	// drop valid, let all reports drain and any add in flight finish
	task automatic settle();
		item_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (BUSY_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sdbm_pkg::CFG_IDX_W-1:0] idx,
			input logic [sdbm_pkg::CFG_DAT_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < sdbm_pkg::CFG_OFF_BASE)
			key_mod[idx[1:0]] = data;
		else
			key_off[idx[1:0]] = data[7:0];
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_keys(input logic [8:0] m0, m1, m2, m3,
			input logic [7:0] o0, o1, o2, o3);
		logic [8:0] mods [NUM_KEYS];
		logic [7:0] offs [NUM_KEYS];
		mods = '{m0, m1, m2, m3};
		offs = '{o0, o1, o2, o3};
		settle();
		for (int k = 0; k < NUM_KEYS; k++) begin
			write_reg(sdbm_pkg::CFG_MOD_BASE + 3'(k), mods[k]);
			write_reg(sdbm_pkg::CFG_OFF_BASE + 3'(k), {1'b0, offs[k]});
		end
	endtask

	// reset setup: every key disabled, so nothing lands in the descriptor
	task automatic test_disabled_keys();
		send_request(add_item(2'd0, 1'b1, 32'hffff_ffff, 1'b1));
		send_request(match_item(3'd0, 32'd0, 1'b1));
	endtask

	// hash extremes, top bit of the store, out-of-store and disabled keys
	task automatic test_hash_positions();
		program_keys(9'd256, 9'd1, 9'd511, 9'd0, 8'd0, 8'd255, 8'd255, 8'd0);
		send_request(add_item(2'd0, 1'b1, 32'd0, 1'b0));
		send_request(add_item(2'd0, 1'b1, 32'hffff_ffff, 1'b0));
		send_request(add_item(2'd1, 1'b1, 32'd12345, 1'b0));
		send_request(add_item(2'd2, 1'b1, 32'hffff_ffff, 1'b0));
		send_request(add_item(2'd3, 1'b1, 32'h8000_0001, 1'b0));
		send_request(add_item(2'd0, 1'b0, 32'h1234_5678, 1'b1));
		for (int w = 0; w < DESC_WORDS; w++)
			send_request(match_item(3'(w), 32'hffff_ffff, w == DESC_WORDS - 1));
		send_request(match_item(3'd0, 32'd0, 1'b1));
		send_request(match_item(3'd7, 32'h7fff_ffff, 1'b1));
	endtask

	// unused action code: no report even with last_word set, then a clear
	task automatic test_unused_action();
		sdbm_pkg::item_t r;
		r           = random_item();
		r.action    = sdbm_pkg::ACT_NONE;
		r.last_word = 1'b1;
		send_request(r);
		send_request(random_item() == r ? r : r);
		r.action = sdbm_pkg::ACT_CLEAR;
		send_request(r);
		send_request(match_item(3'd7, 32'd0, 1'b1));
	endtask

	// a run of facts with unbound keys back to back, then a count report
	task automatic test_fact_count();
		sdbm_pkg::item_t r;
		steady = 1'b1;
		r        = random_item();
		r.action = sdbm_pkg::ACT_CLEAR;
		send_request(r);
		for (int n = 0; n < 20; n++)
			send_request(add_item(2'($urandom_range(0, 3)), 1'b0, $urandom(), 1'b1));
		send_request(match_item(3'd3, $urandom(), 1'b1));
		steady = 1'b0;
	endtask

	// mostly whole facts and whole matches with random content, some noise
	task automatic test_random_traffic(input int count);
		int              first;
		int              roll;
		int              nkeys;
		int              nwords;
		logic [2:0]      w;
		logic [31:0]     mine;
		logic [31:0]     other;
		sdbm_pkg::item_t r;
		first = requests_sent;
		while (requests_sent - first < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				nkeys = $urandom_range(1, NUM_KEYS);
				for (int k = 0; k < nkeys; k++)
					send_request(add_item(2'($urandom_range(0, 3)),
						$urandom_range(0, 99) < 85, $urandom(), k == nkeys - 1));
			end else if (roll < 85) begin
				nwords = ($urandom_range(0, 3) != 0) ? DESC_WORDS : $urandom_range(1, 8);
				for (int i = 0; i < nwords; i++) begin
					w    = (nwords == DESC_WORDS) ? 3'(i) : 3'($urandom_range(0, 7));
					mine = desc_words[w];
					case ($urandom_range(0, 2))
						0: other = mine | $urandom();
						1: other = (mine | $urandom()) & ~(mine & (~mine + 32'd1));
						default: other = $urandom();
					endcase
					send_request(match_item(w, other, i == nwords - 1));
				end
			end else if (roll < 90) begin
				r        = random_item();
				r.action = sdbm_pkg::ACT_CLEAR;
				send_request(r);
			end else begin
				send_request(random_item());
			end
		end
	endtask

	// receiver backpressure
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= 1'b0;
			hold_left = pick_gap();
		end
	end

	// report checker
	always @(posedge clk) begin
		sdbm_pkg::result_t due;
		if (arst_n && result_valid && !result_stall) begin
			reports_seen++;
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected report subset=%0b records=%0d", $time,
					result.is_subset, result.records_added);
				error_count++;
			end else begin
				due = reports_due.pop_front();
				if (result.is_subset !== due.is_subset) begin
					$display("%0t: is_subset expected %0b got %0b", $time,
						due.is_subset, result.is_subset);
					error_count++;
				end
				if (result.records_added !== due.records_added) begin
					$display("%0t: records_added expected %0d got %0d", $time,
						due.records_added, result.records_added);
					error_count++;
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no handshake for %0d cycles, %0d reports outstanding", $time,
			IDLE_LIMIT, reports_due.size());
		$display("[superimposed_descriptor_build_match_core] ERROR");
		$finish;
	end

	initial begin
		foreach (desc_words[i])
			desc_words[i] = '0;
		foreach (key_mod[k]) begin
			key_mod[k] = '0;
			key_off[k] = '0;
		end
		fact_count    = '0;
		subset_so_far = 1'b1;
		error_count   = 0;
		requests_sent = 0;
		reports_seen  = 0;
		reg_writes    = 0;
		steady        = 1'b0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_keys();
		test_hash_positions();
		test_unused_action();
		test_fact_count();

		program_keys(9'd256, 9'd256, 9'd256, 9'd256, 8'd0, 8'd64, 8'd128, 8'd192);
		test_random_traffic(120);
		program_keys(9'd1, 9'd2, 9'd3, 9'd31, 8'd255, 8'd0, 8'd224, 8'd7);
		steady = 1'b1;
		test_random_traffic(90);
		steady = 1'b0;
		program_keys(9'd0, 9'd511, 9'd5, 9'd256, 8'd0, 8'd255, 8'd31, 8'd100);
		test_random_traffic(120);
		program_keys(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
			9'($urandom_range(1, 256)), 9'($urandom_range(1, 64)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		test_random_traffic(130);

		settle();
		$display("covered %0d requests over 6 key setups (%0d register writes)",
			requests_sent, reg_writes);
		$display("checked %0d subset reports, %0d mismatches", reports_seen, error_count);
		if (error_count == 0)
			$display("[superimposed_descriptor_build_match_core] OK");
		else
			$display("[superimposed_descriptor_build_match_core] ERROR");
		$finish;
	end

endmodule

@@ superimposed_descriptor_build_match_core.f @@
rtl/sdbm_pkg.sv
rtl/sdbm_ram.sv
rtl/sdbm_moddiv.sv
rtl/superimposed_descriptor_build_match_core.sv
test/superimposed_descriptor_build_match_core_tb.sv
